@@ hdl/cbip_pkg.sv @@
// Shared types, constants and codes for the custom base integer parser.
// Used by the channel interfaces, the front, queue and back modules and the top level.
package cbip_pkg;

  localparam int SYM_W          = 8;
  localparam int SLOTS          = 16;
  localparam int IDX_W          = 4;
  localparam int LEN_W          = 5;
  localparam int MAX_BASE       = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int OUT_W          = 32;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_W-1:0] ALPHA_LOW_RST  = 64'd3978425819141910832;
  localparam logic [CFG_W-1:0] ALPHA_HIGH_RST = 64'd14648;
  localparam logic [LEN_W-1:0] BASE_LEN_RST   = 5'd10;

  localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
  localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'd32;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_LOW  = 2'd0,
    REG_ALPHA_HIGH = 2'd1,
    REG_BASE_LEN   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SPACE = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  // Classification of one character, as handed from front to back.
  typedef struct packed {
    logic             space;
    logic             plus;
    logic             minus;
    logic             zero;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic             alpha_ok;
    logic             last;
  } cls_t;

endpackage

@@ hdl/cbip_in_if.sv @@
// Character input channel: valid/ready handshake carrying one character word.
// Depends on cbip_pkg.
interface cbip_in_if
  import cbip_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

@@ hdl/cbip_out_if.sv @@
// Result output channel: valid/ready handshake carrying the parsed value word.
// Depends on cbip_pkg.
interface cbip_out_if
  import cbip_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  logic                    alphabet_valid;

  modport source (output valid, output value, output alphabet_valid, input ready);
  modport sink   (input valid, input value, input alphabet_valid, output ready);
endinterface

@@ hdl/cbip_front.sv @@
// Front end: takes character words, matches them against the digit alphabet and
// classifies them for the back end. Depends on cbip_pkg and cbip_in_if.
module cbip_front
  import cbip_pkg::*;
(
  input  logic             rst,
  cbip_in_if.sink          chars,
  input  logic [CFG_W-1:0] alpha_low,
  input  logic [CFG_W-1:0] alpha_high,
  input  logic [LEN_W-1:0] base_length,
  input  logic             full,
  output logic             push,
  output cls_t             cls
);

  function automatic logic is_ws(input logic [SYM_W-1:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  logic [SYM_W-1:0] sym [SLOTS];
  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] len;
  logic             found;
  logic [IDX_W-1:0] idx;
  logic             ok;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      sym[i] = (i < SLOTS / 2) ? alpha_low[(i % (SLOTS / 2)) * SYM_W +: SYM_W]
                               : alpha_high[(i % (SLOTS / 2)) * SYM_W +: SYM_W];
    end
  end

  // The alphabet ends at the radix limit or at its first zero byte.
  always_comb begin
    lim = (base_length > LEN_W'(MAX_BASE)) ? LEN_W'(MAX_BASE) : base_length;
    len = lim;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < lim) && (sym[i] == '0)) begin
        len = LEN_W'(i);
      end
    end
  end

  // Lowest matching position wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < len) && (sym[i] == chars.symbol)) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ok = (len >= LEN_W'(2));
    for (int i = 0; i < SLOTS; i++) begin
      if (LEN_W'(i) < len) begin
        if (is_ws(sym[i]) || (sym[i] == CH_PLUS) || (sym[i] == CH_MINUS)) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < SLOTS; j++) begin
          if ((LEN_W'(j) < len) && (sym[j] == sym[i])) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  assign chars.ready = !full && !rst;
  assign push        = chars.valid && chars.ready;

  always_comb begin
    cls.space    = is_ws(chars.symbol);
    cls.plus     = (chars.symbol == CH_PLUS);
    cls.minus    = (chars.symbol == CH_MINUS);
    cls.zero     = (chars.symbol == '0);
    cls.found    = found;
    cls.idx      = idx;
    cls.len      = len;
    cls.alpha_ok = ok;
    cls.last     = chars.is_last;
  end

endmodule

@@ hdl/cbip_queue.sv @@
// Short queue of classified characters between front and back end.
// Depends on cbip_pkg.
module cbip_queue
  import cbip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_data,
  input  logic pop,
  output cls_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/cbip_back.sv @@
// Back end: runs the parse state machine, multiply-accumulates digits and holds
// the result word in an output register. Depends on cbip_pkg and cbip_out_if.
module cbip_back
  import cbip_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  cls_t      head,
  output logic      pop,
  cbip_out_if.source result
);

  phase_t                  phase;
  phase_t                  phase_next;
  logic                    negative;
  logic                    negative_next;
  logic [VALUE_BITS-1:0]   acc;
  logic [VALUE_BITS-1:0]   acc_next;
  logic [VALUE_BITS-1:0]   prod;
  logic [VALUE_BITS-1:0]   signed_val;
  logic                    res_valid;
  logic [OUT_W-1:0]        res_value;
  logic                    res_ok;

  // A non-final character always drains; the final one waits for the output register.
  assign pop = !empty && (!head.last || !res_valid || result.ready);

  assign prod = acc * VALUE_BITS'(head.len);

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    acc_next      = acc;
    if ((phase_next == PH_SPACE) && !head.space) begin
      phase_next = PH_SIGN;
    end
    if (phase_next == PH_SIGN) begin
      if (head.minus) begin
        negative_next = !negative;
      end else if (!head.plus) begin
        phase_next = PH_DIGIT;
      end
    end
    if (phase_next == PH_DIGIT) begin
      if (head.found && !head.zero) begin
        acc_next = prod + VALUE_BITS'(head.idx);
      end else begin
        phase_next = PH_DONE;
      end
    end
    signed_val = negative_next ? (VALUE_BITS'(0) - acc_next) : acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      negative <= 1'b0;
      acc      <= '0;
    end else if (pop) begin
      if (head.last) begin
        phase    <= PH_SPACE;
        negative <= 1'b0;
        acc      <= '0;
      end else begin
        phase    <= phase_next;
        negative <= negative_next;
        acc      <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && head.last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      res_value <= OUT_W'(signed_val);
      res_ok    <= head.alpha_ok;
    end
  end

  assign result.valid          = res_valid;
  assign result.value          = res_value;
  assign result.alphabet_valid = res_ok;

endmodule

@@ hdl/custom_base_integer_parser_unit.sv @@
// Channel   Dir  Word contents                     Handshake
// chars     in   symbol[7:0], is_last              valid/ready
// result    out  value[31:0] signed, alphabet_valid valid/ready
// cfg       in   cfg_index[1:0], cfg_wdata[63:0]   cfg_we, no wait
//
// One character word is taken per cycle while the queue is not full; the final word of a
// string is written into the queue on acceptance and then loaded into the back end's
// result register once that register is free.
// The back end's multiply-accumulate takes one digit a cycle while no result stalls it.
// Synchronous reset restores the default decimal alphabet and clears the parse state.
// A stalled result backs up the two-entry queue and then drops chars.ready.
module custom_base_integer_parser_unit
  import cbip_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  cbip_in_if.sink              chars,
  cbip_out_if.source           result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] alpha_low;
  logic [CFG_W-1:0] alpha_high;
  logic [LEN_W-1:0] base_length;

  logic push;
  logic pop;
  logic full;
  logic empty;
  cls_t push_data;
  cls_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_low   <= ALPHA_LOW_RST;
      alpha_high  <= ALPHA_HIGH_RST;
      base_length <= BASE_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_LOW:  alpha_low   <= cfg_wdata;
        REG_ALPHA_HIGH: alpha_high  <= cfg_wdata;
        REG_BASE_LEN:   base_length <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cbip_front u_front (
    .rst         (rst),
    .chars       (chars),
    .alpha_low   (alpha_low),
    .alpha_high  (alpha_high),
    .base_length (base_length),
    .full        (full),
    .push        (push),
    .cls         (push_data)
  );

  cbip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .full      (full),
    .empty     (empty)
  );

  cbip_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ hdl/cbip_checker.sv @@
// Port-level checks for the custom base integer parser, attached by bind.
// Depends on cbip_pkg and the top level's channel ports.
module cbip_checker
  import cbip_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_value,
  input logic             out_ok
);

  // The output register is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The queue can only be full while a result word is stuck at the output.
  a_full_means_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled without a pending result");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_ok))
    else $error("result word changed while stalled");

endmodule

bind custom_base_integer_parser_unit cbip_checker u_cbip_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (chars.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_value (result.value),
  .out_ok    (result.alphabet_valid)
);
